/* sv/pbrc_pkg.sv */
package pbrc_pkg;

	// Field widths of the request and result items.
	localparam int BUTTON_W   = 2;
	localparam int BS_W       = 14;
	localparam int SLIDER_W   = 18;
	localparam int RATE_W     = 17;
	localparam int IN_TDATA_W = 40;

	// Field positions inside s_tdata, lowest bit first.
	localparam int IN_BUTTON_LSB  = 0;
	localparam int IN_PRESSED_LSB = IN_BUTTON_LSB + BUTTON_W;
	localparam int IN_BS_LSB      = IN_PRESSED_LSB + 1;
	localparam int IN_SLIDER_LSB  = IN_BS_LSB + BS_W;

	// Register widths and the configuration port.
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 18;
	localparam int DIR_W   = 2;
	localparam int RANGE_W = 16;
	localparam int PCT_W   = 14;
	localparam int SENS_W  = 12;
	localparam int SR_W    = 18;

	// Serial divider: numerator head bits and divisor width.
	localparam int NUM_W = 21;
	localparam int DEN_W = 30;

	// Width of the refusal test sum and its fixed bias of 1.0 scaled by 2^32.
	localparam int TEST_W = 38;
	localparam logic signed [TEST_W-1:0] TEST_BIAS = 38'sh01_0000_0000;

	// Scale factors of the two step formulas.
	localparam int STEP_SCALE = 10000;
	localparam int LIN_SCALE  = 100;

	// Saturation bound of the rate output.
	localparam int RATE_MAX = 2**(RATE_W-1) - 1;

	typedef logic [DIR_W-1:0] dir_t;

	// Direction bits of the pressed mask.
	localparam dir_t DIR_NONE = 2'b00;
	localparam dir_t DIR_DOWN = 2'b01;
	localparam dir_t DIR_UP   = 2'b10;

	// Button codes.
	localparam logic [BUTTON_W-1:0] BTN_UP         = 2'd0;
	localparam logic [BUTTON_W-1:0] BTN_DOWN       = 2'd1;
	localparam logic [BUTTON_W-1:0] BTN_UP_SMALL   = 2'd2;
	localparam logic [BUTTON_W-1:0] BTN_DOWN_SMALL = 2'd3;

	// Request kinds and ramp modes.
	localparam logic REQ_BUTTON = 1'b0;
	localparam logic REQ_TICK   = 1'b1;
	localparam logic MODE_STEP  = 1'b0;
	localparam logic MODE_LIN   = 1'b1;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_AW-1:0] {
		REG_RAMP_MODE   = 3'd0,
		REG_RATE_DIR    = 3'd1,
		REG_RATE_RANGE  = 3'd2,
		REG_COARSE_PCT  = 3'd3,
		REG_FINE_PCT    = 3'd4,
		REG_SENSITIVITY = 3'd5,
		REG_SAMPLE_RATE = 3'd6
	} cfg_reg_t;

	// Register reset values.
	localparam logic [DIR_W-1:0]   RST_RATE_DIR    = 2'b01;
	localparam logic [RANGE_W-1:0] RST_RATE_RANGE  = 16'd5243;
	localparam logic [PCT_W-1:0]   RST_COARSE_PCT  = 14'd400;
	localparam logic [PCT_W-1:0]   RST_FINE_PCT    = 14'd200;
	localparam logic [SENS_W-1:0]  RST_SENSITIVITY = 12'd250;
	localparam logic [SR_W-1:0]    RST_SAMPLE_RATE = 18'd44100;

endpackage

/* sv/pitch_bend_ramp_controller_top.sv */
// Temporary pitch-bend controller.
// Requests arrive on the s_ stream: s_tuser selects a button event or a buffer tick,
// s_tdata carries the button, press flag, buffer size and rate slider. Every request
// gives one result on the m_ stream: the bend (Q1.FRAC_BITS), the rate offset and the
// active flag. Registers are written through cfg_we/cfg_addr/cfg_wdata; the user
// must write them only while idle, which the block itself does not enforce. One
// request is worked on at a time. The products and quotients are formed by a
// bit-serial shift-add multiplier (one bit of the range per cycle) and a bit-serial
// restoring divider (one quotient bit per cycle). s_tready rises in the same cycle
// as m_tvalid. The result waits in an output register, so the next request is
// taken while the receiver stalls; only a second finished result waits for the
// register to drain. Reset clears the buttons, the bend and the linear step, and
// loads the register defaults. There is no clearing pass.
module pitch_bend_ramp_controller_top #(
	parameter int FRAC_BITS = 16,
	localparam int BEND_W = FRAC_BITS + 2,
	localparam int OUT_W = ((BEND_W + pbrc_pkg::RATE_W + 1 + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// button, pressed, buffer_samples, rate_slider
	input  logic [pbrc_pkg::IN_TDATA_W-1:0] s_tdata,
	// req_type
	input  logic                           s_tuser,
	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// bend_value, bend_rate, bend_active
	output logic [OUT_W-1:0]               m_tdata,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [pbrc_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [pbrc_pkg::CFG_DW-1:0]    cfg_wdata
);
	import pbrc_pkg::*;

	localparam int MW = (BEND_W > SLIDER_W) ? BEND_W : SLIDER_W;
	localparam int MX = MW + 1;
	localparam int AW = MW + RANGE_W;
	localparam int QW = FRAC_BITS + 3;
	localparam int VQW = FRAC_BITS + 4;
	localparam int VW = FRAC_BITS + 5;
	localparam int SX = SLIDER_W + 1;
	localparam int DIV_STEP_N = NUM_W + FRAC_BITS + 16;
	localparam int DIV_LIN_N = NUM_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_STEP_N);
	localparam int SHIFT = 32 - FRAC_BITS;
	localparam int ONE = 2**FRAC_BITS;
	localparam int FOUR = 4 * ONE;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SLIDE,
		ST_FIRST,
		ST_DIV,
		ST_STEP,
		ST_SUM,
		ST_SET,
		ST_SECOND,
		ST_RLOAD,
		ST_RMUL,
		ST_FIN
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic                ramp_mode_q;
	logic [DIR_W-1:0]    rate_dir_q;
	logic [RANGE_W-1:0]  rate_range_q;
	logic [PCT_W-1:0]    coarse_pct_q;
	logic [PCT_W-1:0]    fine_pct_q;
	logic [SENS_W-1:0]   ramp_sens_q;
	logic [SR_W-1:0]     sample_rate_q;

	// Controller state.
	logic [3:0]                 held_q;
	dir_t                       mask_q;
	dir_t                       cdir_q;
	logic                       started_q;
	logic signed [BEND_W-1:0]   bend_q;
	logic [QW-1:0]              lin_step_q;
	logic                       ret_second_q;
	logic [CNT_W-1:0]           cnt_q;

	// Serial multiplier and divider.
	logic [MW-1:0]       mul_a_q;
	logic [RANGE_W-1:0]  mul_b_q;
	logic [AW-1:0]       acc_q;
	logic [NUM_W-1:0]    num_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;
	logic [QW-1:0]       q_q;
	logic                ovf_q;

	// Per-request working values.
	logic [BS_W-1:0]            bs_q;
	logic                       slider_neg_q;
	logic signed [TEST_W-1:0]   term_q;
	logic [QW-1:0]              m_q;
	logic                       sub_q;
	logic signed [VQW-1:0]      v_q;

	// Output register.
	logic                       m_tvalid_q;
	logic signed [BEND_W-1:0]   out_bend_q;
	logic signed [RATE_W-1:0]   out_rate_q;
	logic                       out_active_q;

	// Request fields.
	logic [BUTTON_W-1:0]        in_button;
	logic                       in_pressed;
	logic [BS_W-1:0]            in_bs;
	logic signed [SLIDER_W-1:0] in_slider;

	assign in_button  = s_tdata[IN_BUTTON_LSB +: BUTTON_W];
	assign in_pressed = s_tdata[IN_PRESSED_LSB];
	assign in_bs      = s_tdata[IN_BS_LSB +: BS_W];
	assign in_slider  = s_tdata[IN_SLIDER_LSB +: SLIDER_W];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({out_active_q, out_rate_q, out_bend_q});

	// Sign and magnitude of the slider direction multiplier.
	logic       dir_neg;
	logic [1:0] dir_mag;

	always_comb begin
		dir_neg = rate_dir_q[DIR_W-1];
		unique case (rate_dir_q)
			2'b00:   dir_mag = 2'd0;
			2'b10:   dir_mag = 2'd2;
			default: dir_mag = 2'd1;
		endcase
	end

	// Button event update of held bits, pressed mask and direction.
	dir_t       btn_bit;
	logic [3:0] btn_onehot;
	logic [3:0] held_n;
	dir_t       mask_n;
	dir_t       cdir_n;

	always_comb begin
		btn_bit = (in_button == BTN_UP || in_button == BTN_UP_SMALL) ? DIR_UP : DIR_DOWN;
		btn_onehot = 4'b0001 << in_button;
		held_n = in_pressed ? (held_q | btn_onehot) : (held_q & ~btn_onehot);
		mask_n = mask_q;
		cdir_n = cdir_q;
		priority if (in_pressed && (mask_q & btn_bit) == DIR_NONE) begin
			mask_n = mask_q | btn_bit;
			cdir_n = btn_bit;
		end else if (!in_pressed) begin
			mask_n = mask_q & ~btn_bit;
			cdir_n = mask_q & ~btn_bit;
		end else begin
			mask_n = mask_q;
		end
	end

	// Magnitudes that feed the multiplier.
	logic signed [SX-1:0] slider_x;
	logic signed [SX-1:0] slider_mag;
	logic signed [MX-1:0] bend_x;
	logic signed [MX-1:0] bend_mag;

	always_comb begin
		slider_x = SX'(in_slider);
		slider_mag = slider_x[SX-1] ? -slider_x : slider_x;
		bend_x = MX'(bend_q);
		bend_mag = bend_x[MX-1] ? -bend_x : bend_x;
	end

	// One shift-add step of the multiplier, range bit by range bit.
	logic [MW:0]   mul_sum;
	logic [AW-1:0] mul_next;

	always_comb begin
		mul_sum = {1'b0, acc_q[AW-1:RANGE_W]} + (mul_b_q[0] ? {1'b0, mul_a_q} : '0);
		mul_next = {mul_sum, acc_q[RANGE_W-1:1]};
	end

	// Product scaled by the direction magnitude, and the two uses of it.
	logic [AW:0]              prod_x;
	logic signed [TEST_W-1:0] prod_t;
	logic signed [TEST_W-1:0] slider_term;
	logic [MX-1:0]            rate_mag;
	logic [RATE_W-1:0]        rate_neg_mag;
	logic signed [RATE_W-1:0] rate_val;

	always_comb begin
		unique case (dir_mag)
			2'd1:    prod_x = {1'b0, acc_q};
			2'd2:    prod_x = {acc_q, 1'b0};
			default: prod_x = '0;
		endcase
		prod_t = TEST_W'(prod_x);
		slider_term = (slider_neg_q ^ dir_neg) ? -prod_t : prod_t;
		rate_mag = prod_x[AW:RANGE_W];
		rate_neg_mag = (rate_mag > MX'(RATE_MAX + 1)) ? RATE_W'(RATE_MAX + 1) : RATE_W'(rate_mag);
		if (bend_q[BEND_W-1] ^ dir_neg) begin
			rate_val = -rate_neg_mag;
		end else begin
			rate_val = (rate_mag > MX'(RATE_MAX)) ? RATE_W'(RATE_MAX) : RATE_W'(rate_mag);
		end
	end

	// One restoring step of the divider.
	logic [DEN_W:0]   div_trial;
	logic [DEN_W:0]   div_diff;
	logic             div_bit;
	logic [DEN_W-1:0] rem_next;
	logic [QW-1:0]    q_sat;

	always_comb begin
		div_trial = {rem_q, num_q[NUM_W-1]};
		div_diff = div_trial - {1'b0, den_q};
		div_bit = (div_trial >= {1'b0, den_q});
		rem_next = div_bit ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
		q_sat = ovf_q ? '1 : q_q;
	end

	// Stepping operands: first held button in priority order.
	logic [PCT_W-1:0] step_pct;
	logic             step_sub;
	logic [DEN_W-1:0] step_den;
	logic [DEN_W-1:0] lin_den;
	logic [NUM_W-1:0] lin_num;
	logic [QW-1:0]    step_mag;

	always_comb begin
		priority if (held_q[BTN_UP]) begin
			step_pct = coarse_pct_q;
			step_sub = 1'b0;
		end else if (held_q[BTN_DOWN]) begin
			step_pct = coarse_pct_q;
			step_sub = 1'b1;
		end else if (held_q[BTN_UP_SMALL]) begin
			step_pct = fine_pct_q;
			step_sub = 1'b0;
		end else begin
			step_pct = fine_pct_q;
			step_sub = 1'b1;
		end
		step_den = DEN_W'(rate_range_q) * DEN_W'(STEP_SCALE);
		lin_den = DEN_W'(sample_rate_q) * DEN_W'(ramp_sens_q);
		lin_num = NUM_W'(bs_q) * NUM_W'(LIN_SCALE);
		unique case (dir_mag)
			2'd1:    step_mag = q_sat;
			2'd2:    step_mag = q_sat[QW-1] ? '1 : {q_sat[QW-2:0], 1'b0};
			default: step_mag = '0;
		endcase
	end

	// New bend before the refusal test, limited to four times unity.
	logic signed [VW-1:0]     sum_b;
	logic signed [VW-1:0]     sum_m;
	logic signed [VW-1:0]     sum_v;
	logic signed [VQW-1:0]    v_clamp;
	logic signed [TEST_W-1:0] v_ext;
	logic signed [TEST_W-1:0] test_sum;
	logic signed [BEND_W-1:0] bend_new;

	always_comb begin
		sum_b = VW'(bend_q);
		sum_m = VW'(m_q);
		sum_v = sub_q ? (sum_b - sum_m) : (sum_b + sum_m);
		if (sum_v > VW'(FOUR)) begin
			v_clamp = VQW'(FOUR);
		end else if (sum_v < VW'(-FOUR)) begin
			v_clamp = VQW'(-FOUR);
		end else begin
			v_clamp = VQW'(sum_v);
		end
		// Refused when 1 + dir*range*slider + value is negative.
		v_ext = TEST_W'(v_q);
		test_sum = TEST_BIAS + term_q + (v_ext <<< SHIFT);
		if (v_q > VQW'(ONE)) begin
			bend_new = BEND_W'(ONE);
		end else if (v_q < VQW'(-ONE)) begin
			bend_new = BEND_W'(-ONE);
		end else begin
			bend_new = BEND_W'(v_q);
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_mode_q <= MODE_STEP;
			rate_dir_q <= RST_RATE_DIR;
			rate_range_q <= RST_RATE_RANGE;
			coarse_pct_q <= RST_COARSE_PCT;
			fine_pct_q <= RST_FINE_PCT;
			ramp_sens_q <= RST_SENSITIVITY;
			sample_rate_q <= RST_SAMPLE_RATE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_RAMP_MODE:   ramp_mode_q <= cfg_wdata[0];
				REG_RATE_DIR:    rate_dir_q <= cfg_wdata[DIR_W-1:0];
				REG_RATE_RANGE:  rate_range_q <= cfg_wdata[RANGE_W-1:0];
				REG_COARSE_PCT:  coarse_pct_q <= cfg_wdata[PCT_W-1:0];
				REG_FINE_PCT:    fine_pct_q <= cfg_wdata[PCT_W-1:0];
				REG_SENSITIVITY: ramp_sens_q <= cfg_wdata[SENS_W-1:0];
				REG_SAMPLE_RATE: sample_rate_q <= cfg_wdata[SR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer with its datapath and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q <= '0;
			mask_q <= DIR_NONE;
			cdir_q <= DIR_NONE;
			started_q <= 1'b0;
			bend_q <= '0;
			lin_step_q <= '0;
			ret_second_q <= 1'b0;
			cnt_q <= '0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			acc_q <= '0;
			num_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			q_q <= '0;
			ovf_q <= 1'b0;
			bs_q <= '0;
			slider_neg_q <= 1'b0;
			term_q <= '0;
			m_q <= '0;
			sub_q <= 1'b0;
			v_q <= '0;
			m_tvalid_q <= 1'b0;
			out_bend_q <= '0;
			out_rate_q <= '0;
			out_active_q <= 1'b0;
		end else begin
			// The final state reloads the output register itself.
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == REQ_TICK) begin
							mul_a_q <= MW'(slider_mag[SLIDER_W-1:0]);
							mul_b_q <= rate_range_q;
							acc_q <= '0;
							cnt_q <= CNT_W'(RANGE_W - 1);
							bs_q <= in_bs;
							slider_neg_q <= in_slider[SLIDER_W-1];
							state_q <= ST_SLIDE;
						end else begin
							held_q <= held_n;
							mask_q <= mask_n;
							cdir_q <= cdir_n;
							state_q <= ST_RLOAD;
						end
					end
				end
				// range * |slider|
				ST_SLIDE: begin
					acc_q <= mul_next;
					mul_b_q <= mul_b_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIRST;
					end
				end
				// First tick of a press: start the step division, or the linear step division in linear mode.
				ST_FIRST: begin
					term_q <= slider_term;
					ret_second_q <= 1'b1;
					rem_q <= '0;
					q_q <= '0;
					ovf_q <= 1'b0;
					if (mask_q != DIR_NONE && !started_q) begin
						started_q <= 1'b1;
						if (ramp_mode_q == MODE_STEP) begin
							priority if (rate_range_q == '0) begin
								state_q <= ST_RLOAD;
							end else if (held_q != '0) begin
								num_q <= NUM_W'(step_pct);
								den_q <= step_den;
								cnt_q <= CNT_W'(DIV_STEP_N - 1);
								sub_q <= step_sub ^ dir_neg;
								state_q <= ST_DIV;
							end else begin
								state_q <= ST_SECOND;
							end
						end else begin
							num_q <= lin_num;
							den_q <= lin_den;
							cnt_q <= CNT_W'(DIV_LIN_N - 1);
							state_q <= ST_DIV;
						end
					end else begin
						state_q <= ST_SECOND;
					end
				end
				// One quotient bit per cycle; bits above the kept width saturate.
				ST_DIV: begin
					num_q <= num_q << 1;
					rem_q <= rem_next;
					q_q <= {q_q[QW-2:0], div_bit};
					ovf_q <= ovf_q | q_q[QW-1];
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (ramp_mode_q == MODE_STEP) begin
						m_q <= step_mag;
						state_q <= ST_SUM;
					end else begin
						lin_step_q <= q_sat;
						state_q <= ST_SECOND;
					end
				end
				ST_SUM: begin
					v_q <= v_clamp;
					state_q <= ST_SET;
				end
				ST_SET: begin
					if (!test_sum[TEST_W-1]) begin
						bend_q <= bend_new;
					end
					state_q <= ret_second_q ? ST_SECOND : ST_RLOAD;
				end
				// Ramp while held, or return to zero after release.
				ST_SECOND: begin
					ret_second_q <= 1'b0;
					if (ramp_mode_q == MODE_LIN) begin
						priority if (cdir_q == DIR_UP) begin
							m_q <= lin_step_q;
							sub_q <= 1'b0;
							state_q <= ST_SUM;
						end else if (cdir_q == DIR_DOWN) begin
							m_q <= lin_step_q;
							sub_q <= 1'b1;
							state_q <= ST_SUM;
						end else if (cdir_q == DIR_NONE && started_q) begin
							started_q <= 1'b0;
							v_q <= '0;
							state_q <= ST_SET;
						end else begin
							state_q <= ST_RLOAD;
						end
					end else if (started_q && cdir_q == DIR_NONE) begin
						started_q <= 1'b0;
						v_q <= '0;
						state_q <= ST_SET;
					end else begin
						state_q <= ST_RLOAD;
					end
				end
				ST_RLOAD: begin
					mul_a_q <= bend_mag[MW-1:0];
					mul_b_q <= rate_range_q;
					acc_q <= '0;
					cnt_q <= CNT_W'(RANGE_W - 1);
					state_q <= ST_RMUL;
				end
				// range * |bend|
				ST_RMUL: begin
					acc_q <= mul_next;
					mul_b_q <= mul_b_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						out_bend_q <= bend_q;
						out_rate_q <= rate_val;
						out_active_q <= started_q;
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The stored bend never leaves the unit interval.
	a_bend_range: assert property (@(posedge clk) disable iff (!arst_n)
		bend_q <= BEND_W'(ONE) && bend_q >= BEND_W'(-ONE))
		else $error("bend left the unit interval");

	// The direction is zero exactly when no direction is pressed.
	a_dir_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(cdir_q == DIR_NONE) == (mask_q == DIR_NONE))
		else $error("direction and pressed mask disagree");

	// A request is worked on alone.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// A result is only raised by the final state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the final state");

endmodule

/* test/testbench.sv */
module testbench;
	import pbrc_pkg::*;

	localparam int FB = 16;
	localparam int BEND_W = FB + 2;
	localparam int OUT_W = ((BEND_W + RATE_W + 1 + 7) / 8) * 8;
	localparam longint ONE = 64'sd1 << FB;
	localparam longint TWO32 = 64'sd4294967296;
	localparam int DRAIN_GAP = 100;
	localparam int HOLD_AT = 375;
	localparam int HOLD_LEN = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int CHUNKS = 8;
	localparam int CHUNK_ITEMS = 100;

	// One request as the sender sees it.
	typedef struct {
		logic                kind;
		logic [BUTTON_W-1:0] button;
		logic                pressed;
		logic [BS_W-1:0]     samples;
		logic signed [SLIDER_W-1:0] slider;
	} bend_req_t;

	// One result; packed so that bend_value lands in the lowest bits.
	typedef struct packed {
		logic                     active;
		logic signed [RATE_W-1:0] rate;
		logic signed [BEND_W-1:0] value;
	} bend_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	pitch_bend_ramp_controller_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stimulus and expectation stores.
	bend_req_t pending_req_q[$];
	bend_result_t bend_expected_q[$];
	bend_req_t on_bus;
	bend_result_t mon_want, mon_seen;

	int total_items = 0;
	int event_cnt = 0;
	int tick_cnt = 0;
	int settings_cnt = 0;
	int got_cnt = 0;
	int err_cnt = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stall_cycles = 0;

	// Shadow of the registers.
	logic               mode_r;
	logic [DIR_W-1:0]   dir_r;
	logic [RANGE_W-1:0] range_r;
	logic [PCT_W-1:0]   coarse_r;
	logic [PCT_W-1:0]   fine_r;
	logic [SENS_W-1:0]  sens_r;
	logic [SR_W-1:0]    srate_r;

	// Shadow of the controller state.
	logic [3:0] held_btn;
	dir_t       dir_mask;
	dir_t       cur_dir;
	logic       ramp_started;
	longint     bend_now;
	logic [31:0] lin_step;

	function automatic longint dir_sign();
		return longint'($signed(dir_r));
	endfunction

	// Store a new bend unless the resulting rate would go negative, then clamp to +-1.
	function automatic void commit_bend(longint v, longint s);
		longint rng;
		longint ratio;
		rng = range_r;
		if (v > 4 * ONE) v = 4 * ONE;
		if (v < -4 * ONE) v = -4 * ONE;
		ratio = ONE * TWO32 + dir_sign() * rng * s * ONE;
		if (ratio + v * TWO32 < 0) return;
		if (v > ONE) v = ONE;
		if (v < -ONE) v = -ONE;
		bend_now = v;
	endfunction

	// One stepping increment for a percentage setting.
	function automatic longint step_size(logic [PCT_W-1:0] pct);
		longint unsigned num;
		longint unsigned den;
		longint q;
		num = pct;
		num = num << (FB + 16);
		den = range_r;
		den = den * STEP_SCALE;
		q = num / den;
		return dir_sign() * q;
	endfunction

	// Advance the bend on one audio buffer.
	function automatic void advance_tick(logic [BS_W-1:0] bs, logic signed [SLIDER_W-1:0] sl);
		longint s;
		longint ls;
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		s = sl;
		if (dir_mask != DIR_NONE && !ramp_started) begin
			ramp_started = 1'b1;
			if (mode_r == MODE_STEP) begin
				// A zero range only marks the sequence as started.
				if (range_r == 0) return;
				if (held_btn[BTN_UP])
					commit_bend(bend_now + step_size(coarse_r), s);
				else if (held_btn[BTN_DOWN])
					commit_bend(bend_now - step_size(coarse_r), s);
				else if (held_btn[BTN_UP_SMALL])
					commit_bend(bend_now + step_size(fine_r), s);
				else if (held_btn[BTN_DOWN_SMALL])
					commit_bend(bend_now - step_size(fine_r), s);
			end else begin
				den = srate_r;
				den = den * sens_r;
				num = bs;
				num = (num * LIN_SCALE) << FB;
				if (den == 0) q = 64'hFFFF_FFFF;
				else q = num / den;
				lin_step = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			end
		end
		ls = lin_step;
		if (mode_r == MODE_LIN) begin
			if (cur_dir != DIR_NONE) begin
				if (cur_dir == DIR_UP) commit_bend(bend_now + ls, s);
				else if (cur_dir == DIR_DOWN) commit_bend(bend_now - ls, s);
			end else if (ramp_started) begin
				ramp_started = 1'b0;
				commit_bend(0, s);
			end
		end else if (ramp_started && cur_dir == DIR_NONE) begin
			ramp_started = 1'b0;
			commit_bend(0, s);
		end
	endfunction

	// Track held buttons, the pressed mask and the current direction.
	function automatic void press_button(logic [BUTTON_W-1:0] b, logic pr);
		dir_t bitv;
		bitv = (b == BTN_UP || b == BTN_UP_SMALL) ? DIR_UP : DIR_DOWN;
		held_btn[b] = pr;
		if (pr && (dir_mask & bitv) == DIR_NONE) begin
			dir_mask = dir_mask | bitv;
			cur_dir = bitv;
		end else if (!pr) begin
			dir_mask = dir_mask & ~bitv;
			cur_dir = dir_mask;
		end
	endfunction

	// Apply one accepted request and queue the result it should give.
	function automatic void predict_bend(bend_req_t r);
		bend_result_t res;
		longint prod;
		longint rate;
		longint rng;
		if (r.kind == REQ_TICK) advance_tick(r.samples, r.slider);
		else press_button(r.button, r.pressed);
		rng = range_r;
		prod = dir_sign() * bend_now * rng;
		rate = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);
		if (rate > RATE_MAX) rate = RATE_MAX;
		if (rate < -RATE_MAX - 1) rate = -RATE_MAX - 1;
		res.value = bend_now[BEND_W-1:0];
		res.rate = rate[RATE_W-1:0];
		res.active = ramp_started;
		bend_expected_q.push_back(res);
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_req(bend_req_t r);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[IN_BUTTON_LSB +: BUTTON_W] = r.button;
		d[IN_PRESSED_LSB] = r.pressed;
		d[IN_BS_LSB +: BS_W] = r.samples;
		d[IN_SLIDER_LSB +: SLIDER_W] = r.slider;
		return d;
	endfunction

	function automatic logic [BS_W-1:0] any_samples();
		if ($urandom_range(9) == 0) return BS_W'($urandom);
		return BS_W'($urandom_range(1, 8192));
	endfunction

	function automatic logic signed [SLIDER_W-1:0] any_slider();
		if ($urandom_range(7) == 0) return SLIDER_W'($urandom);
		return SLIDER_W'($urandom_range(0, 131072) - 65536);
	endfunction

	// Button events carry random bits in the unused fields.
	function automatic void queue_button(logic [BUTTON_W-1:0] b, logic pr);
		bend_req_t r;
		r.kind = REQ_BUTTON;
		r.button = b;
		r.pressed = pr;
		r.samples = BS_W'($urandom);
		r.slider = SLIDER_W'($urandom);
		pending_req_q.push_back(r);
		event_cnt++;
		total_items++;
	endfunction

	function automatic void queue_tick(logic [BS_W-1:0] bs, logic signed [SLIDER_W-1:0] sl);
		bend_req_t r;
		r.kind = REQ_TICK;
		r.button = BUTTON_W'($urandom);
		r.pressed = 1'($urandom);
		r.samples = bs;
		r.slider = sl;
		pending_req_q.push_back(r);
		tick_cnt++;
		total_items++;
	endfunction

	// Mostly press, hold over a few ticks, release; the rest is loose events and ticks.
	function automatic void queue_random_chunk(int n);
		int stop;
		logic [BUTTON_W-1:0] first;
		logic [BUTTON_W-1:0] second;
		bit two;
		stop = total_items + n;
		while (total_items < stop) begin
			if ($urandom_range(9) < 8) begin
				first = BUTTON_W'($urandom);
				second = BUTTON_W'($urandom);
				two = ($urandom_range(3) == 0);
				queue_button(first, 1'b1);
				if (two) queue_button(second, 1'b1);
				repeat ($urandom_range(1, 6)) queue_tick(any_samples(), any_slider());
				queue_button(first, 1'b0);
				if (two) begin
					queue_tick(any_samples(), any_slider());
					queue_button(second, 1'b0);
				end
				repeat ($urandom_range(1, 2)) queue_tick(any_samples(), any_slider());
			end else if ($urandom_range(1) == 1) begin
				queue_button(BUTTON_W'($urandom), 1'($urandom));
			end else begin
				queue_tick(BS_W'($urandom), SLIDER_W'($urandom));
			end
		end
	endfunction

	// Wait until every queued request has come back, then let the block settle.
	task automatic drain();
		while (got_cnt != total_items) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// Write all seven registers; only called while the block is idle.
	task automatic load_settings(input logic m, input logic [DIR_W-1:0] d,
			input logic [RANGE_W-1:0] rg, input logic [PCT_W-1:0] cp,
			input logic [PCT_W-1:0] fp, input logic [SENS_W-1:0] sv,
			input logic [SR_W-1:0] sr);
		logic [CFG_DW-1:0] vals [7];
		vals[REG_RAMP_MODE] = CFG_DW'(m);
		vals[REG_RATE_DIR] = CFG_DW'(d);
		vals[REG_RATE_RANGE] = CFG_DW'(rg);
		vals[REG_COARSE_PCT] = CFG_DW'(cp);
		vals[REG_FINE_PCT] = CFG_DW'(fp);
		vals[REG_SENSITIVITY] = CFG_DW'(sv);
		vals[REG_SAMPLE_RATE] = CFG_DW'(sr);
		for (int i = 0; i < 7; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_addr <= CFG_AW'(i);
			cfg_wdata <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_r = m;
		dir_r = d;
		range_r = rg;
		coarse_r = cp;
		fine_r = fp;
		sens_r = sv;
		srate_r = sr;
		settings_cnt++;
	endtask

	// Request driver: holds an item until it is taken, then maybe idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_bend(on_bus);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = pending_req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= pack_req(on_bus);
					s_tuser <= on_bus.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result and drives the receiver's ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_cnt++;
				mon_seen = m_tdata[BEND_W+RATE_W:0];
				if (bend_expected_q.size() == 0) begin
					$error("result with no request pending: tdata %h", m_tdata);
					err_cnt++;
				end else begin
					mon_want = bend_expected_q.pop_front();
					if (mon_seen.value !== mon_want.value) begin
						$error("bend_value: expected %0d, got %0d",
							mon_want.value, mon_seen.value);
						err_cnt++;
					end
					if (mon_seen.rate !== mon_want.rate) begin
						$error("bend_rate: expected %0d, got %0d",
							mon_want.rate, mon_seen.rate);
						err_cnt++;
					end
					if (mon_seen.active !== mon_want.active) begin
						$error("bend_active: expected %0d, got %0d",
							mon_want.active, mon_seen.active);
						err_cnt++;
					end
				end
			end
			// One long hold-off lets the block fill up and stall its input.
			if (!hold_done && got_cnt >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles in which neither side moves a request or result.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [DIR_W-1:0] rnd_dir;

		// Reset values of the registers and the state.
		mode_r = MODE_STEP;
		dir_r = RST_RATE_DIR;
		range_r = RST_RATE_RANGE;
		coarse_r = RST_COARSE_PCT;
		fine_r = RST_FINE_PCT;
		sens_r = RST_SENSITIVITY;
		srate_r = RST_SAMPLE_RATE;
		held_btn = '0;
		dir_mask = DIR_NONE;
		cur_dir = DIR_NONE;
		ramp_started = 1'b0;
		bend_now = 0;
		lin_step = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 38;
		recv_idle_pct = 81;

		// Reset settings, stepping: idle tick, a coarse press, crossed small buttons,
		// and a second press of a direction already held.
		queue_tick(14'd0, 18'sd0);
		queue_button(BTN_UP, 1'b1);
		queue_tick(14'd8192, 18'sd65536);
		queue_tick(14'd16383, -18'sd65536);
		queue_button(BTN_UP, 1'b0);
		queue_tick(14'd1, 18'sd131071);
		queue_button(BTN_DOWN_SMALL, 1'b1);
		queue_button(BTN_UP_SMALL, 1'b1);
		queue_tick(14'd100, -18'sd131072);
		queue_button(BTN_UP_SMALL, 1'b0);
		queue_button(BTN_DOWN_SMALL, 1'b0);
		queue_tick(14'd100, 18'sd0);
		queue_button(BTN_UP, 1'b1);
		queue_button(BTN_UP_SMALL, 1'b1);
		queue_tick(14'd512, 18'sd1000);
		queue_button(BTN_UP, 1'b0);
		queue_tick(14'd512, 18'sd1000);
		drain();

		// Linear ramp with a zero divisor: the step saturates.
		load_settings(MODE_LIN, RST_RATE_DIR, RST_RATE_RANGE, RST_COARSE_PCT,
			RST_FINE_PCT, 12'd0, RST_SAMPLE_RATE);
		queue_button(BTN_DOWN, 1'b1);
		queue_tick(14'd64, 18'sd0);
		queue_tick(14'd64, 18'sd0);
		queue_button(BTN_DOWN, 1'b0);
		queue_tick(14'd64, 18'sd0);
		drain();

		// Full range and largest steps; the release reset is then refused.
		load_settings(MODE_STEP, 2'b01, 16'hFFFF, 14'd10000, 14'h3FFF, 12'hFFF, 18'h3FFFF);
		queue_button(BTN_UP, 1'b1);
		queue_tick(14'd8192, 18'sd0);
		queue_button(BTN_UP, 1'b0);
		queue_tick(14'd8192, -18'sd131072);
		drain();

		// Zero range with the odd direction code.
		load_settings(MODE_STEP, 2'b10, 16'd0, RST_COARSE_PCT, RST_FINE_PCT,
			RST_SENSITIVITY, RST_SAMPLE_RATE);
		queue_button(BTN_DOWN, 1'b1);
		queue_tick(14'd256, 18'sd30000);
		queue_button(BTN_DOWN, 1'b0);
		queue_tick(14'd256, 18'sd30000);

		// Random sequences, a fresh register setting per chunk.
		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			drain();
			if (chunk == 3) begin
				send_idle_pct = 81;
				recv_idle_pct = 38;
			end else if (chunk == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (chunk)
				0: load_settings(MODE_STEP, 2'b11, 16'd655, 14'd0, 14'd0, 12'd50, 18'd8000);
				1: load_settings(MODE_LIN, 2'b01, 16'd58982, 14'd10000, 14'd10000,
					12'd2500, 18'd192000);
				2: load_settings(MODE_LIN, 2'b11, 16'd655, 14'd10000, 14'd0,
					12'd50, 18'd8000);
				default: begin
					rnd_dir = ($urandom_range(4) == 0) ? DIR_W'($urandom) :
						(($urandom_range(1) == 1) ? 2'b01 : 2'b11);
					load_settings(chunk[0] ? MODE_LIN : MODE_STEP, rnd_dir,
						($urandom_range(9) == 0) ? RANGE_W'($urandom) :
							RANGE_W'($urandom_range(655, 58982)),
						($urandom_range(9) == 0) ? PCT_W'($urandom) :
							PCT_W'($urandom_range(10000)),
						($urandom_range(9) == 0) ? PCT_W'($urandom) :
							PCT_W'($urandom_range(10000)),
						($urandom_range(9) == 0) ? SENS_W'($urandom) :
							SENS_W'($urandom_range(50, 2500)),
						($urandom_range(9) == 0) ? SR_W'($urandom) :
							SR_W'($urandom_range(8000, 192000)));
				end
			endcase
			queue_random_chunk(CHUNK_ITEMS);
		end
		drain();

		if (bend_expected_q.size() != 0)
			$error("%0d expected results never arrived", bend_expected_q.size());
		$display("Covered %0d button events and %0d buffer ticks under %0d register settings,",
			event_cnt, tick_cnt, settings_cnt);
		$display("in stepping and linear modes, with both sides idling and one long output stall.");
		if (err_cnt == 0 && bend_expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
